/* src/setc_pkg.sv */
// Shared codes and types of the scope edge-trigger capture block.
package setc_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LEVEL   = 1'b0;
    localparam logic CFG_FALLING = 1'b1;

    // Fixed field widths and reset values
    localparam int LEVEL_BITS  = 10;
    localparam int OFFSET_BITS = 7;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 10'd512;

    // Status from the controller to the output stage
    typedef struct packed {
        logic busy;
        logic load;
    } setc_status_t;

endpackage

/* src/setc_ring_ram.sv */
// Sample ring memory: one write port, one read port with registered data.
module setc_ring_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the stored sample
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/setc_ctrl.sv */
// Controller: pointers, configuration, trigger search sequencer and window read.
module setc_ctrl #(
    parameter int RING_DEPTH   = 2048,
    parameter int WINDOW_WIDTH = 128,
    parameter int SEARCH_SPAN  = 1024,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_accept,
    input  logic [1:0]                             operation,
    input  logic [SAMPLE_BITS-1:0]                 sample_in,
    input  logic [setc_pkg::OFFSET_BITS-1:0]       window_offset,
    input  logic                                   cfg_write,
    input  logic                                   cfg_index,
    input  logic [setc_pkg::LEVEL_BITS-1:0]        cfg_data,
    output setc_pkg::setc_status_t                 status,
    output logic [SAMPLE_BITS-1:0]                 res_sample,
    output logic                                   res_found,
    output logic [$clog2(RING_DEPTH)-1:0]          res_position,
    output logic [$clog2(RING_DEPTH)-1:0]          res_newest,
    output logic                                   ram_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]          ram_wr_addr,
    output logic [SAMPLE_BITS-1:0]                 ram_wr_data,
    output logic [$clog2(RING_DEPTH)-1:0]          ram_rd_addr,
    input  logic [SAMPLE_BITS-1:0]                 ram_rd_data
);

    import setc_pkg::*;

    localparam int IW       = $clog2(RING_DEPTH);
    localparam int XW       = IW + 2;
    localparam int KW       = $clog2(SEARCH_SPAN);
    localparam int CW       = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int HALF_MOD = (WINDOW_WIDTH / 2) % RING_DEPTH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PRIME  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_RWAIT  = 2'd3;

    logic [1:0]            state_reg,   state_next;
    logic [IW-1:0]         wp_reg,      wp_next;
    logic [IW-1:0]         trig_reg,    trig_next;
    logic                  found_reg,   found_next;
    logic [LEVEL_BITS-1:0] level_reg;
    logic                  falling_reg;
    logic [IW-1:0]         cur_reg,     cur_next;
    logic [SAMPLE_BITS-1:0] prev_reg,   prev_next;
    logic [KW-1:0]         k_reg,       k_next;

    logic [IW-1:0] wp_inc;
    logic [IW-1:0] start_pos;
    logic [IW-1:0] start_inc;
    logic [IW-1:0] cur_dec;
    logic [XW-1:0] read_sum;
    logic [IW-1:0] read_addr;
    logic [CW-1:0] a_ext;
    logic [CW-1:0] b_ext;
    logic [CW-1:0] lvl_ext;
    logic          hit;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        if (p == IW'(RING_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        if (p == '0)
            r = IW'(RING_DEPTH - 1);
        else
            r = p - 1'b1;
        return r;
    endfunction

    // Ring arithmetic for pointers and addresses
    always_comb
    begin
        wp_inc    = ring_inc(wp_reg);
        cur_dec   = ring_dec(cur_reg);
        if (XW'(wp_reg) >= XW'(HALF_MOD))
            start_pos = IW'(XW'(wp_reg) - XW'(HALF_MOD));
        else
            start_pos = IW'(XW'(wp_reg) + XW'(RING_DEPTH - HALF_MOD));
        start_inc = ring_inc(start_pos);
        read_sum  = XW'(trig_reg) + XW'(window_offset) + XW'(RING_DEPTH - HALF_MOD);
        if (read_sum >= XW'(2 * RING_DEPTH))
            read_addr = IW'(read_sum - XW'(2 * RING_DEPTH));
        else if (read_sum >= XW'(RING_DEPTH))
            read_addr = IW'(read_sum - XW'(RING_DEPTH));
        else
            read_addr = IW'(read_sum);
    end

    // Crossing test between the arriving sample and the later neighbour
    always_comb
    begin
        a_ext   = CW'(ram_rd_data);
        b_ext   = CW'(prev_reg);
        lvl_ext = CW'(level_reg);
        if (falling_reg)
            hit = (a_ext > lvl_ext) && (b_ext < lvl_ext);
        else
            hit = (a_ext < lvl_ext) && (b_ext > lvl_ext);
    end

    // Sequence items and the backward search walk
    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        trig_next    = trig_reg;
        found_next   = found_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        k_next       = k_reg;
        status.busy  = (state_reg != ST_IDLE);
        status.load  = 1'b0;
        res_sample   = '0;
        res_found    = found_reg;
        res_position = trig_reg;
        res_newest   = wp_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = wp_inc;
        ram_wr_data  = sample_in;
        ram_rd_addr  = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (operation == OP_SEARCH)
                    ram_rd_addr = start_inc;
                else
                    ram_rd_addr = read_addr;
                if (in_accept)
                begin
                    unique case (operation)
                        OP_STORE:
                        begin
                            wp_next     = wp_inc;
                            ram_wr_en   = 1'b1;
                            status.load = 1'b1;
                            res_newest  = wp_inc;
                        end
                        OP_SEARCH:
                        begin
                            cur_next   = start_pos;
                            state_next = ST_PRIME;
                        end
                        OP_READ:
                        begin
                            state_next = ST_RWAIT;
                        end
                        OP_NONE:
                        begin
                            status.load = 1'b1;
                        end
                    endcase
                end
            end
            ST_PRIME:
            begin
                // hold the sample after the start position, fetch the start
                prev_next  = ram_rd_data;
                k_next     = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    trig_next    = cur_reg;
                    found_next   = 1'b1;
                    status.load  = 1'b1;
                    res_found    = 1'b1;
                    res_position = cur_reg;
                    state_next   = ST_IDLE;
                end
                else if (k_reg == KW'(SEARCH_SPAN - 1))
                begin
                    found_next  = 1'b0;
                    status.load = 1'b1;
                    res_found   = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ram_rd_addr = cur_dec;
                    cur_next    = cur_dec;
                    prev_next   = ram_rd_data;
                    k_next      = k_reg + 1'b1;
                end
            end
            ST_RWAIT:
            begin
                status.load = 1'b1;
                res_sample  = ram_rd_data;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= IW'(RING_DEPTH - 1);
            trig_reg    <= '0;
            found_reg   <= 1'b0;
            level_reg   <= LEVEL_RESET;
            falling_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            trig_reg  <= trig_next;
            found_reg <= found_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LEVEL:   level_reg   <= cfg_data;
                    CFG_FALLING: falling_reg <= cfg_data[0];
                endcase
            end
        end
    end

    // Advance the search walk registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        k_reg    <= k_next;
    end

endmodule

/* src/scope_edge_trigger_capture.sv */
// Top level of the scope edge-trigger capture block with its output register.
//
// Input channel (in_valid/in_stall) carries one beat per item: operation,
// sample_in and window_offset. Output channel (out_valid/out_stall) returns
// one beat per item with sample_out, trigger_found, trigger_position and
// newest_index as they stand after the item has taken effect.
// Configuration: cfg_write with cfg_index 0 writes trigger_level, index 1
// writes trigger_falling (cfg_data bit 0).
// Results and throughput, while the receiver does not stall:
//   store, unused codes: result in the cycle after the beat, one item a cycle.
//   window read: result passes ST_RWAIT, then the output register.
//   search: walks at most SEARCH_SPAN entries, fewer when a crossing is near;
//   the walk reads one ring entry a cycle through the single memory read port.
// Only one read or search is in flight; in_stall is high while it works.
// Reset clears pointers, the trigger state and configuration; the ring itself
// is not cleared, so no clearing pass is needed.
// When the receiver stalls, the result beat holds in the output register and
// no new item is taken until the register is free.
module scope_edge_trigger_capture #(
    parameter int RING_DEPTH   = 2048,
    parameter int WINDOW_WIDTH = 128,
    parameter int SEARCH_SPAN  = 1024,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [SAMPLE_BITS-1:0]            sample_in,
    input  logic [setc_pkg::OFFSET_BITS-1:0]  window_offset,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [SAMPLE_BITS-1:0]            sample_out,
    output logic                              trigger_found,
    output logic [$clog2(RING_DEPTH)-1:0]     trigger_position,
    output logic [$clog2(RING_DEPTH)-1:0]     newest_index,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [setc_pkg::LEVEL_BITS-1:0]   cfg_data
);

    import setc_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);

    setc_status_t           status;
    logic                   in_accept;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic                   found_out_reg;
    logic [IW-1:0]          position_out_reg;
    logic [IW-1:0]          newest_out_reg;
    logic [SAMPLE_BITS-1:0] res_sample;
    logic                   res_found;
    logic [IW-1:0]          res_position;
    logic [IW-1:0]          res_newest;
    logic                   ram_wr_en;
    logic [IW-1:0]          ram_wr_addr;
    logic [SAMPLE_BITS-1:0] ram_wr_data;
    logic [IW-1:0]          ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rd_data;

    // Stall while an item is at work or the result beat is held
    assign in_stall  = status.busy || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    setc_ctrl #(
        .RING_DEPTH   (RING_DEPTH),
        .WINDOW_WIDTH (WINDOW_WIDTH),
        .SEARCH_SPAN  (SEARCH_SPAN),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .operation    (operation),
        .sample_in    (sample_in),
        .window_offset(window_offset),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .res_sample   (res_sample),
        .res_found    (res_found),
        .res_position (res_position),
        .res_newest   (res_newest),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    setc_ring_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Hold the result beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (status.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (status.load)
        begin
            sample_out_reg   <= res_sample;
            found_out_reg    <= res_found;
            position_out_reg <= res_position;
            newest_out_reg   <= res_newest;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sample_out       = sample_out_reg;
    assign trigger_found    = found_out_reg;
    assign trigger_position = position_out_reg;
    assign newest_index     = newest_out_reg;

    // A result is only loaded into a free or departing output register
    assert property (@(posedge clk) disable iff (!rst_n)
        status.load |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a held beat");

    // A window read delivers its result in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == OP_READ)) |=> status.load)
        else $error("window read result missing");

    // A store beat appears at the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == OP_STORE)) |=> out_valid)
        else $error("store result missing");

    // No result while the block is idle and no item was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!status.busy && !in_accept) |-> !status.load)
        else $error("spurious result");

endmodule

/* sim/scope_edge_trigger_capture_test.sv */
// Self-checking testbench of the scope edge-trigger capture block.
`timescale 1ns / 100ps

typedef struct packed {
    logic [9:0]  sample_out;
    logic        found;
    logic [10:0] position;
    logic [10:0] newest;
} capture_view_t;

// Predicted ring, pointers and trigger state, with the queue of views still owed
class capture_tracker;
    localparam int RING_DEPTH  = 2048;
    localparam int HALF_WINDOW = 64;
    localparam int SEARCH_SPAN = 1024;
    localparam int SHOWN_LIMIT = 40;

    logic [9:0]  ring [RING_DEPTH];
    logic [10:0] newest;
    logic [10:0] trig_pos;
    logic        found;
    logic [setc_pkg::LEVEL_BITS-1:0] level;
    logic        falling;
    capture_view_t pending [$];
    int store_count;
    int search_count;
    int hit_count;
    int read_count;
    int unused_count;
    int checked_count;
    int error_count;

    function new();
        foreach (ring[i])
            ring[i] = '0;
        newest   = 11'(RING_DEPTH - 1);
        trig_pos = '0;
        found    = 1'b0;
        level    = setc_pkg::LEVEL_RESET;
        falling  = 1'b0;
    endfunction

    // An entry holds a sample once the store pointer has reached it since reset
    function bit is_written(logic [10:0] idx);
        return store_count >= RING_DEPTH || int'(idx) < store_count;
    endfunction

    // A search may only look at stored entries; the walk ends at the first crossing
    function bit search_allowed();
        logic [10:0] p;
        logic [10:0] q;
        bit          hit;
        for (int k = 0; k < SEARCH_SPAN; k++)
        begin
            p = 11'(newest - HALF_WINDOW - k);
            q = p + 1'b1;
            if (!is_written(p) || !is_written(q))
                return 1'b0;
            if (falling)
                hit = (ring[p] > level) && (ring[q] < level);
            else
                hit = (ring[p] < level) && (ring[q] > level);
            if (hit)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function bit read_allowed(logic [setc_pkg::OFFSET_BITS-1:0] offset);
        logic [10:0] p;
        p = 11'(trig_pos - HALF_WINDOW + offset);
        return is_written(p);
    endfunction

    // Walk back from half a window behind the newest entry; stop at the nearest crossing
    function void locate_crossing();
        logic [10:0] p;
        logic [10:0] q;
        logic [9:0]  a;
        logic [9:0]  b;
        bit          hit;
        hit = 1'b0;
        for (int k = 0; k < SEARCH_SPAN && !hit; k++)
        begin
            p = 11'(newest - HALF_WINDOW - k);
            q = p + 1'b1;
            a = ring[p];
            b = ring[q];
            if (falling)
                hit = (a > level) && (b < level);
            else
                hit = (a < level) && (b > level);
            if (hit)
                trig_pos = p;
        end
        found = hit;
        if (hit)
            hit_count++;
    endfunction

    // Apply one accepted input beat and queue the view it must produce
    function void take_beat(logic [1:0] op, logic [9:0] value,
                            logic [setc_pkg::OFFSET_BITS-1:0] offset);
        capture_view_t v;
        logic [10:0]   p;
        v.sample_out = '0;
        case (op)
            setc_pkg::OP_STORE:
            begin
                newest       = newest + 1'b1;
                ring[newest] = value;
                store_count++;
            end
            setc_pkg::OP_SEARCH:
            begin
                locate_crossing();
                search_count++;
            end
            setc_pkg::OP_READ:
            begin
                p            = 11'(trig_pos - HALF_WINDOW + offset);
                v.sample_out = ring[p];
                read_count++;
            end
            default:
                unused_count++;
        endcase
        v.found    = found;
        v.position = trig_pos;
        v.newest   = newest;
        pending.push_back(v);
    endfunction

    task report_mismatch(string msg);
        if (error_count < SHOWN_LIMIT)
            $display("error at result %0d: %s", checked_count, msg);
        error_count++;
    endtask

    // Compare one accepted result beat with the oldest queued view
    task check_beat(logic [9:0] sample_out, logic trigger_found,
                    logic [10:0] trigger_position, logic [10:0] newest_index);
        capture_view_t want;
        if (pending.size() == 0)
        begin
            report_mismatch("result beat with no item outstanding");
            return;
        end
        want = pending.pop_front();
        checked_count++;
        if (sample_out !== want.sample_out)
            report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                      sample_out, want.sample_out));
        if (trigger_found !== want.found)
            report_mismatch($sformatf("trigger_found %0b, predicted %0b",
                                      trigger_found, want.found));
        if (trigger_position !== want.position)
            report_mismatch($sformatf("trigger_position %0d, predicted %0d",
                                      trigger_position, want.position));
        if (newest_index !== want.newest)
            report_mismatch($sformatf("newest_index %0d, predicted %0d",
                                      newest_index, want.newest));
    endtask
endclass

module scope_edge_trigger_capture_test;
    import setc_pkg::*;

    localparam int QUIET_LIMIT     = 8000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int FILL_BEATS      = 70;
    // stores after which every search walk sees only written entries
    localparam int FULL_STORES     = 1088;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] operation;
    logic [9:0] sample_in;
    logic [OFFSET_BITS-1:0] window_offset;
    logic out_valid;
    logic out_stall;
    logic [9:0] sample_out;
    logic trigger_found;
    logic [10:0] trigger_position;
    logic [10:0] newest_index;
    logic cfg_write;
    logic cfg_index;
    logic [LEVEL_BITS-1:0] cfg_data;

    capture_tracker tracker = new();
    bit hold_off_req = 1'b0;
    int burst_left = 0;
    int beats_sent = 0;
    int settings_count = 0;
    int wave_val = 512;
    int wave_dir = 1;

    scope_edge_trigger_capture dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .sample_in        (sample_in),
        .window_offset    (window_offset),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_out       (sample_out),
        .trigger_found    (trigger_found),
        .trigger_position (trigger_position),
        .newest_index     (newest_index),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random walk with bounces, jumps and the odd sample sitting on the level
    function automatic logic [9:0] next_wave();
        int step;
        if ($urandom_range(0, 29) == 0)
            return tracker.level;
        if ($urandom_range(0, 39) == 0)
            wave_val = $urandom_range(0, 1023);
        else
        begin
            if ($urandom_range(0, 15) == 0)
                wave_dir = -wave_dir;
            step = $urandom_range(1, 48);
            wave_val += (wave_dir > 0) ? step : -step;
            if (wave_val > 1023)
            begin
                wave_val = 1023;
                wave_dir = -1;
            end
            if (wave_val < 0)
            begin
                wave_val = 0;
                wave_dir = 1;
            end
        end
        return wave_val[9:0];
    endfunction

    // Offer one beat, hold it until taken, then maybe open a gap
    task automatic send_beat(logic [1:0] op, logic [9:0] value,
                             logic [OFFSET_BITS-1:0] offset);
        if ((op == OP_SEARCH && !tracker.search_allowed()) ||
            (op == OP_READ && !tracker.read_allowed(offset)))
            op = OP_STORE;
        in_valid      <= 1'b1;
        operation     <= op;
        sample_in     <= value;
        window_offset <= offset;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        tracker.take_beat(op, value, offset);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(0, 24);
        end
    endtask

    // Stop offering and wait until every owed result beat has come back
    task automatic settle_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [LEVEL_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_LEVEL)
            tracker.level = data;
        else
            tracker.falling = data[0];
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_trigger(logic [LEVEL_BITS-1:0] lvl, logic fall);
        settle_results();
        write_register(CFG_LEVEL, lvl);
        write_register(CFG_FALLING, {(LEVEL_BITS-1)'($urandom_range(0, 511)), fall});
        settings_count++;
    endtask

    // Mostly a waveform, a search and some window reads; sometimes raw noise
    task automatic run_sequence();
        int n;
        if ($urandom_range(0, 99) < 85)
        begin
            n = $urandom_range(2, 60);
            repeat (n) send_beat(OP_STORE, next_wave(), OFFSET_BITS'($urandom_range(0, 127)));
            send_beat(OP_SEARCH, 10'($urandom_range(0, 1023)),
                      OFFSET_BITS'($urandom_range(0, 127)));
            n = $urandom_range(1, 6);
            repeat (n) send_beat(OP_READ, 10'($urandom_range(0, 1023)),
                                 OFFSET_BITS'($urandom_range(0, 127)));
            if ($urandom_range(0, 7) == 0)
                send_beat(OP_NONE, 10'($urandom_range(0, 1023)),
                          OFFSET_BITS'($urandom_range(0, 127)));
        end
        else
        begin
            n = $urandom_range(1, 10);
            repeat (n) send_beat(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                                 OFFSET_BITS'($urandom_range(0, 127)));
        end
    endtask

    // Check every result beat taken at this edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.check_beat(sample_out, trigger_found, trigger_position, newest_index);
    end

    // Receiver: stall on a changing pattern, with one long hold-off on request
    initial
    begin : receiver
        stall_mode_t mode;
        int          mode_left;
        int          tick;
        mode      = STALL_NONE;
        mode_left = 0;
        tick      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 4) == 0);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
                    default:        out_stall <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("scope_edge_trigger_capture: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int  phase_start;
        bit  hold_done;
        logic [LEVEL_BITS-1:0] lvl;
        logic fall;
        hold_done     = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_STORE;
        sample_in     = '0;
        window_offset = '0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_LEVEL;
        cfg_data      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset trigger level: unused code, field extremes, then a flat run on the level
        send_beat(OP_NONE, 10'd1023, 7'd127);
        send_beat(OP_STORE, 10'd0, 7'd0);
        send_beat(OP_STORE, 10'd1023, 7'd127);
        repeat (FILL_BEATS) send_beat(OP_STORE, 10'd512,
                                      OFFSET_BITS'($urandom_range(0, 127)));
        // Samples equal to the level never trigger; the walk lands on the oldest step
        send_beat(OP_SEARCH, 10'd0, 7'd0);
        send_beat(OP_READ, 10'd0, 7'd64);
        send_beat(OP_READ, 10'd0, 7'd65);
        send_beat(OP_READ, 10'd0, 7'd127);
        // Clean rising crossing, then window reads around it
        send_beat(OP_STORE, 10'd500, 7'd0);
        send_beat(OP_STORE, 10'd520, 7'd0);
        repeat (64) send_beat(OP_STORE, 10'd512, 7'd0);
        send_beat(OP_SEARCH, 10'd1023, 7'd127);
        send_beat(OP_READ, 10'd0, 7'd0);
        send_beat(OP_READ, 10'd0, 7'd127);
        send_beat(OP_READ, 10'd0, 7'd64);
        // Steps that touch the level: nearest valid crossing is the older one
        send_beat(OP_STORE, 10'd500, 7'd0);
        send_beat(OP_STORE, 10'd512, 7'd0);
        send_beat(OP_STORE, 10'd520, 7'd0);
        repeat (64) send_beat(OP_STORE, 10'd512, 7'd0);
        send_beat(OP_SEARCH, 10'd0, 7'd0);
        // Falling crossing
        set_trigger(10'd512, 1'b1);
        send_beat(OP_STORE, 10'd530, 7'd0);
        send_beat(OP_STORE, 10'd490, 7'd0);
        repeat (64) send_beat(OP_STORE, 10'd512, 7'd0);
        send_beat(OP_SEARCH, 10'd0, 7'd0);
        send_beat(OP_READ, 10'd0, 7'd5);

        // Random phases, each under its own trigger setting
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       begin lvl = LEVEL_BITS'($urandom_range(256, 767)); fall = 1'b0; end
                1:       begin lvl = LEVEL_BITS'($urandom_range(256, 767)); fall = 1'b1; end
                2:       begin lvl = '0;                                    fall = 1'b0; end
                3:       begin lvl = LEVEL_BITS'($urandom_range(0, 1023));  fall = 1'b1; end
                4:       begin lvl = 10'd1023;                              fall = 1'b1; end
                default: begin lvl = LEVEL_BITS'($urandom_range(0, 1023));  fall = 1'b0; end
            endcase
            set_trigger(lvl, fall);
            phase_start = beats_sent;
            while (beats_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if (ph == 1 && !hold_done && beats_sent - phase_start >= 60)
                begin
                    hold_off_req = 1'b1;
                    hold_done    = 1'b1;
                end
                run_sequence();
            end
        end

        // Top up the ring so that a full walk only sees stored samples
        while (tracker.store_count < FULL_STORES)
            send_beat(OP_STORE, next_wave(), 7'd0);
        // Level extremes: nothing can cross, position is kept
        set_trigger(10'd1023, 1'b0);
        send_beat(OP_SEARCH, 10'd0, 7'd0);
        send_beat(OP_READ, 10'd0, 7'd0);
        set_trigger(10'd0, 1'b1);
        send_beat(OP_SEARCH, 10'd0, 7'd0);

        settle_results();
        $display("covered %0d stores, %0d searches (%0d hit a crossing),",
                 tracker.store_count, tracker.search_count, tracker.hit_count);
        $display("%0d window reads, %0d unused codes; checked %0d result beats over %0d setups",
                 tracker.read_count, tracker.unused_count, tracker.checked_count,
                 settings_count + 1);
        if (tracker.error_count == 0 && tracker.pending.size() == 0)
            $display("scope_edge_trigger_capture: match");
        else
            $display("scope_edge_trigger_capture: mismatch");
        $finish;
    end
endmodule

/* scope_edge_trigger_capture.f */
src/setc_pkg.sv
src/setc_ring_ram.sv
src/setc_ctrl.sv
src/scope_edge_trigger_capture.sv
sim/scope_edge_trigger_capture_test.sv
